// ===== rtl/stick_command_shaper_defines.svh =====
// Assertion macros for the stick command shaper.
// Used by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef STICK_COMMAND_SHAPER_DEFINES_SVH
`define STICK_COMMAND_SHAPER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SCS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SCS_ASSERT(lbl, prop, msg)
`define SCS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/scs_pkg.sv =====
// Shared types and constants for the stick command shaper.
// No dependencies; used by scs_mac and stick_command_shaper.
package scs_pkg;

  localparam int unsigned TAG_W     = 8;
  localparam int unsigned STICK_W   = 16;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned BAND_W    = 15;
  localparam int unsigned DB_W      = STICK_W + 1;
  localparam int unsigned MAC_A_W   = 24;
  localparam int unsigned MAC_B_W   = 17;
  localparam int unsigned MAC_P_W   = MAC_A_W + MAC_B_W;
  localparam int unsigned BIAS_W    = 16;
  localparam int unsigned TILT_W    = 22;
  localparam int unsigned YAW_W     = 25;
  localparam int unsigned HEIGHT_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 104;

  localparam logic [TAG_W-1:0]  PACKET_TAG_RST    = 8'd66;
  localparam logic [DT_W-1:0]   STEP_LIMIT_RST    = 16'd13107;
  localparam logic [BAND_W-1:0] MAIN_DEADBAND_RST = 15'd13107;
  localparam logic [BAND_W-1:0] TILT_DEADBAND_RST = 15'd4915;

  localparam logic signed [MAC_B_W-1:0] TILT_GAIN = -17'sd40;
  localparam logic signed [MAC_B_W-1:0] THR_GAIN  = 17'sd3;
  localparam logic signed [MAC_B_W-1:0] YAW_GAIN  = -17'sd45;

  // rounding offsets: half an LSB of the Q16 and Q13 shifts
  localparam logic [BIAS_W-1:0] HEIGHT_BIAS = 16'd32768;
  localparam logic [BIAS_W-1:0] YAW_BIAS    = 16'd4096;
  localparam int unsigned HEIGHT_SHIFT = 16;
  localparam int unsigned YAW_SHIFT    = 13;

  localparam logic signed [YAW_W:0] DEG180_FX = 26'sd11796480;
  localparam logic signed [TILT_W-1:0] TILT_MAX = 22'sd1310720;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PACKET_TAG    = 2'd0,
    REG_STEP_LIMIT    = 2'd1,
    REG_MAIN_DEADBAND = 2'd2,
    REG_TILT_DEADBAND = 2'd3
  } cfg_reg_e;

  // one request to the shared multiply-add unit
  typedef struct packed {
    logic                        db_en;  // operand a is the deadbanded stick
    logic signed [STICK_W-1:0]   stick;
    logic        [BAND_W-1:0]    band;
    logic signed [MAC_A_W-1:0]   a;
    logic signed [MAC_B_W-1:0]   b;
    logic        [BIAS_W-1:0]    bias;
  } mac_op_t;

endpackage

// ===== rtl/scs_mac.sv =====
// Shared arithmetic unit: deadband shrink, 24x17 signed multiply, bias add.
// Registered product. Depends on scs_pkg.
module scs_mac (
  input  logic                                  clk_i,
  input  scs_pkg::mac_op_t                      op_i,
  output logic signed [scs_pkg::MAC_P_W-1:0]    p_o
);
  import scs_pkg::*;

  logic signed [DB_W-1:0]    s_ext;
  logic signed [DB_W-1:0]    nb;
  logic signed [DB_W-1:0]    db;
  logic signed [MAC_A_W-1:0] a_sel;
  logic signed [MAC_B_W-1:0] b_s;
  logic signed [MAC_P_W-1:0] bias_ext;
  logic signed [MAC_P_W-1:0] p_d;
  logic signed [MAC_P_W-1:0] p_q;

  always_comb begin
    s_ext = $signed({op_i.stick[STICK_W-1], op_i.stick});
    nb    = $signed({2'b00, op_i.band});
    priority if (s_ext < -nb) begin
      db = s_ext + nb;
    end else if (s_ext > nb) begin
      db = s_ext - nb;
    end else begin
      db = '0;
    end
  end

  always_comb begin
    a_sel    = op_i.db_en ? $signed({{(MAC_A_W-DB_W){db[DB_W-1]}}, db}) : op_i.a;
    b_s      = op_i.b;
    bias_ext = $signed({{(MAC_P_W-BIAS_W){1'b0}}, op_i.bias});
    p_d      = MAC_P_W'(a_sel) * MAC_P_W'(b_s) + bias_ext;
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== rtl/stick_command_shaper.sv =====
// Stick command shaper top level: config registers, sequencer, kept targets.
// Items are handled one at a time: s_axis_tready_o is high only in idle. A matching
// item makes six passes through the single shared multiply-add unit in scs_mac, a
// rejected one none; each then waits in S_DONE until the output register is free.
// Reset (rst_ni low, asynchronous) clears yaw, height, tilt and stab state
// and restores the default tag, step limit and deadbands.
`include "stick_command_shaper_defines.svh"

module stick_command_shaper (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [scs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [scs_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // yaw_stick, throttle_stick, pitch_stick, roll_stick, time_step, stab_byte
  input  logic [scs_pkg::IN_DATA_W-1:0]        s_axis_tdata_i,
  // tag_byte
  input  logic [scs_pkg::TAG_W-1:0]            s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // tilt_x, tilt_y, yaw_target, height_target, stab_on, 2 zero bits
  output logic [scs_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  // accepted
  output logic                                 m_axis_tuser_o
);
  import scs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TX, S_TY, S_H3, S_HD, S_HA, S_YD, S_YA, S_DONE
  } state_e;

  state_e state_q;

  logic [TAG_W-1:0]  packet_tag_q;
  logic [DT_W-1:0]   step_limit_q;
  logic [BAND_W-1:0] main_db_q;
  logic [BAND_W-1:0] tilt_db_q;

  logic signed [STICK_W-1:0] yaw_s_q, thr_s_q, pit_s_q, rol_s_q;
  logic [DT_W-1:0]           dt_q;
  logic                      accepted_q;

  logic signed [YAW_W-1:0]    yaw_acc_q;
  logic signed [HEIGHT_W-1:0] height_acc_q;
  logic signed [TILT_W-1:0]   tilt_x_q, tilt_y_q;
  logic                       stab_q;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_user_q;

  logic in_xfer;
  logic tag_match;
  logic [DT_W-1:0] dt_in;
  logic [DT_W-1:0] dt_clamped;

  mac_op_t                   mac_op;
  logic signed [MAC_P_W-1:0] mac_p;

  logic signed [YAW_W-1:0]    h_step;
  logic signed [YAW_W-1:0]    y_step;
  logic signed [HEIGHT_W:0]   h_sum;
  logic signed [HEIGHT_W-1:0] h_new;
  logic signed [YAW_W:0]      z_sum;
  logic signed [YAW_W-1:0]    z_new;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_tag_q <= PACKET_TAG_RST;
      step_limit_q <= STEP_LIMIT_RST;
      main_db_q    <= MAIN_DEADBAND_RST;
      tilt_db_q    <= TILT_DEADBAND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PACKET_TAG:    packet_tag_q <= cfg_data_i[TAG_W-1:0];
        REG_STEP_LIMIT:    step_limit_q <= cfg_data_i[DT_W-1:0];
        REG_MAIN_DEADBAND: main_db_q    <= cfg_data_i[BAND_W-1:0];
        REG_TILT_DEADBAND: tilt_db_q    <= cfg_data_i[BAND_W-1:0];
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign tag_match = (s_axis_tuser_i == packet_tag_q);
  assign dt_in     = s_axis_tdata_i[79:64];
  assign dt_clamped = (dt_in > step_limit_q) ? step_limit_q : dt_in;

  // operand select for the shared unit
  always_comb begin
    mac_op       = '0;
    mac_op.band  = tilt_db_q;
    unique case (state_q)
      S_TX: begin
        mac_op.db_en = 1'b1;
        mac_op.stick = rol_s_q;
        mac_op.b     = TILT_GAIN;
      end
      S_TY: begin
        mac_op.db_en = 1'b1;
        mac_op.stick = pit_s_q;
        mac_op.b     = TILT_GAIN;
      end
      S_H3: begin
        mac_op.db_en = 1'b1;
        mac_op.stick = thr_s_q;
        mac_op.band  = main_db_q;
        mac_op.b     = THR_GAIN;
      end
      S_HD: begin
        mac_op.a    = mac_p[MAC_A_W-1:0];
        mac_op.b    = $signed({1'b0, dt_q});
        mac_op.bias = HEIGHT_BIAS;
      end
      S_HA: begin
        mac_op.db_en = 1'b1;
        mac_op.stick = yaw_s_q;
        mac_op.band  = main_db_q;
        mac_op.b     = YAW_GAIN;
      end
      S_YD: begin
        mac_op.a    = mac_p[MAC_A_W-1:0];
        mac_op.b    = $signed({1'b0, dt_q});
        mac_op.bias = YAW_BIAS;
      end
      default: mac_op = '0;
    endcase
  end

  scs_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .p_o   (mac_p)
  );

  // floor shift after the bias gives round half up
  assign h_step = mac_p[HEIGHT_SHIFT+YAW_W-1:HEIGHT_SHIFT];
  assign y_step = mac_p[YAW_SHIFT+YAW_W-1:YAW_SHIFT];

  always_comb begin
    h_sum = (HEIGHT_W+1)'(height_acc_q) + (HEIGHT_W+1)'(h_step);
    priority if (h_sum[HEIGHT_W] != h_sum[HEIGHT_W-1]) begin
      h_new = h_sum[HEIGHT_W] ? {1'b1, {(HEIGHT_W-1){1'b0}}} : {1'b0, {(HEIGHT_W-1){1'b1}}};
    end else begin
      h_new = h_sum[HEIGHT_W-1:0];
    end
  end

  always_comb begin
    z_sum = (YAW_W+1)'(yaw_acc_q) + (YAW_W+1)'(y_step);
    priority if (z_sum > DEG180_FX) begin
      z_new = YAW_W'(-DEG180_FX);
    end else if (z_sum < -DEG180_FX) begin
      z_new = YAW_W'(DEG180_FX);
    end else begin
      z_new = z_sum[YAW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      accepted_q   <= 1'b0;
      yaw_acc_q    <= '0;
      height_acc_q <= '0;
      tilt_x_q     <= '0;
      tilt_y_q     <= '0;
      stab_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_user_q   <= 1'b0;
      yaw_s_q      <= '0;
      thr_s_q      <= '0;
      pit_s_q      <= '0;
      rol_s_q      <= '0;
      dt_q         <= '0;
      out_data_q   <= '0;
    end else begin
      if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
        out_user_q  <= accepted_q;
        out_data_q  <= {2'b00, stab_q, height_acc_q, yaw_acc_q, tilt_y_q, tilt_x_q};
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            yaw_s_q    <= s_axis_tdata_i[15:0];
            thr_s_q    <= s_axis_tdata_i[31:16];
            pit_s_q    <= s_axis_tdata_i[47:32];
            rol_s_q    <= s_axis_tdata_i[63:48];
            dt_q       <= dt_clamped;
            accepted_q <= tag_match;
            if (tag_match) begin
              stab_q  <= |s_axis_tdata_i[87:80];
              state_q <= S_TX;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_TX: state_q <= S_TY;
        S_TY: begin
          tilt_x_q <= mac_p[TILT_W-1:0];
          state_q  <= S_H3;
        end
        S_H3: begin
          tilt_y_q <= mac_p[TILT_W-1:0];
          state_q  <= S_HD;
        end
        S_HD: state_q <= S_HA;
        S_HA: begin
          height_acc_q <= h_new;
          state_q      <= S_YD;
        end
        S_YD: state_q <= S_YA;
        S_YA: begin
          yaw_acc_q <= z_new;
          state_q   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `SCS_ASSERT(a_ready_idle, s_axis_tready_o |-> (state_q == S_IDLE), "ready outside idle")
  `SCS_ASSERT(a_reject_holds, (in_xfer && !tag_match) |=> ($stable(height_acc_q) && $stable(yaw_acc_q) && $stable(tilt_x_q) && $stable(stab_q)), "rejected item changed state")
  `SCS_ASSERT_NEVER(a_yaw_range, (yaw_acc_q > DEG180_FX) || (yaw_acc_q < -DEG180_FX), "yaw outside +-180 deg")
  `SCS_ASSERT_NEVER(a_tilt_range, (tilt_x_q > TILT_MAX) || (tilt_x_q < -TILT_MAX) || (tilt_y_q > TILT_MAX) || (tilt_y_q < -TILT_MAX), "tilt out of range")

endmodule
